// ===== rtl/core/ccr_pkg.sv =====
package ccr_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned LenW   = 16;
    localparam int unsigned HdrCntW = 5;
    localparam int unsigned NdW    = 3;
    localparam int unsigned UserW  = 4;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_AVC  = 2'd1;
    localparam logic [1:0] MODE_HEVC = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_UNSUPP    = 2'd2;

    localparam logic [HdrCntW-1:0] AVC_LEN_POS  = 5'd4;
    localparam logic [HdrCntW-1:0] AVC_SPS_POS  = 5'd5;
    localparam logic [HdrCntW-1:0] HEVC_LEN_POS = 5'd21;
    localparam logic [HdrCntW-1:0] HEVC_ARR_POS = 5'd22;

    localparam logic [ByteW-1:0] AVC_LEN_RSV = 8'hFC;
    localparam logic [ByteW-1:0] AVC_SPS_RSV = 8'hE0;
    localparam logic [ByteW-1:0] AVC_SPS_MSK = 8'h1F;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_PPSCNT,
        PH_ARR_TYPE,
        PH_ARR_CNT_HI,
        PH_ARR_CNT_LO,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD
    } t_phase;

    // One accepted byte's worth of results: nd data bytes taken from len
    // (big-endian, bytes above bit 15 are zero), then an optional status.
    typedef struct packed {
        logic [NdW-1:0]  nd;
        logic [LenW-1:0] len;
        logic            st;
        logic [1:0]      code;
        logic            warn;
    } t_desc;

endpackage

// ===== rtl/core/ccr_parse.sv =====
module ccr_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [1:0]                 i_cfg_wr_data,
    input  logic                       i_accept,
    input  logic [ccr_pkg::ByteW-1:0]  i_byte,
    input  logic                       i_last,
    output logic                       o_push,
    output ccr_pkg::t_desc             o_desc
);

    logic [1:0]                   r_mode;
    ccr_pkg::t_phase              r_phase, n_phase;
    logic [ccr_pkg::HdrCntW-1:0]  r_hdr, n_hdr;
    logic [1:0]                   r_psize, n_psize;
    logic [ccr_pkg::LenW-1:0]     r_units, n_units;
    logic [ccr_pkg::ByteW-1:0]    r_arrays, n_arrays;
    logic [ccr_pkg::LenW-1:0]     r_payload, n_payload;
    logic [ccr_pkg::ByteW-1:0]    r_lenhi, n_lenhi;
    logic                         r_pps, n_pps;
    logic                         r_done, n_done;
    logic                         r_warn, n_warn;

    logic                         supported;
    logic                         active;
    logic [ccr_pkg::LenW-1:0]     len_word;

    assign supported = (r_mode == ccr_pkg::MODE_AVC) || (r_mode == ccr_pkg::MODE_HEVC);
    assign active    = i_accept && supported && !r_done;
    assign len_word  = {r_lenhi, i_byte};

    // next parse state
    always_comb begin
        logic fin_unit;
        logic fin_arr;
        fin_unit  = 1'b0;
        fin_arr   = 1'b0;
        n_phase   = r_phase;
        n_hdr     = r_hdr;
        n_psize   = r_psize;
        n_units   = r_units;
        n_arrays  = r_arrays;
        n_payload = r_payload;
        n_lenhi   = r_lenhi;
        n_pps     = r_pps;
        n_done    = r_done;
        n_warn    = r_warn;
        if (active) begin
            unique case (r_phase)
                ccr_pkg::PH_HDR: begin
                    if (r_mode == ccr_pkg::MODE_AVC) begin
                        if (r_hdr == ccr_pkg::AVC_LEN_POS) begin
                            if ((i_byte & ccr_pkg::AVC_LEN_RSV) != ccr_pkg::AVC_LEN_RSV)
                                n_warn = 1'b1;
                            n_psize = i_byte[1:0];
                        end else if (r_hdr == ccr_pkg::AVC_SPS_POS) begin
                            if ((i_byte & ccr_pkg::AVC_SPS_RSV) != ccr_pkg::AVC_SPS_RSV)
                                n_warn = 1'b1;
                            n_units = {11'd0, i_byte[4:0]};
                            n_pps   = 1'b0;
                            n_phase = (i_byte[4:0] == 5'd0) ? ccr_pkg::PH_PPSCNT
                                                            : ccr_pkg::PH_LEN_HI;
                        end
                    end else begin
                        if (r_hdr == ccr_pkg::HEVC_LEN_POS) begin
                            n_psize = i_byte[1:0];
                        end else if (r_hdr == ccr_pkg::HEVC_ARR_POS) begin
                            n_arrays = i_byte;
                            if (i_byte == '0)
                                n_done = 1'b1;
                            else
                                n_phase = ccr_pkg::PH_ARR_TYPE;
                        end
                    end
                    n_hdr = r_hdr + 5'd1;
                end
                ccr_pkg::PH_PPSCNT: begin
                    n_units = {8'd0, i_byte};
                    n_pps   = 1'b1;
                    if (i_byte == '0)
                        n_done = 1'b1;
                    else
                        n_phase = ccr_pkg::PH_LEN_HI;
                end
                ccr_pkg::PH_ARR_TYPE: begin
                    n_phase = ccr_pkg::PH_ARR_CNT_HI;
                end
                ccr_pkg::PH_ARR_CNT_HI: begin
                    n_lenhi = i_byte;
                    n_phase = ccr_pkg::PH_ARR_CNT_LO;
                end
                ccr_pkg::PH_ARR_CNT_LO: begin
                    n_units = len_word;
                    if (len_word == '0)
                        fin_arr = 1'b1;
                    else
                        n_phase = ccr_pkg::PH_LEN_HI;
                end
                ccr_pkg::PH_LEN_HI: begin
                    n_lenhi = i_byte;
                    n_phase = ccr_pkg::PH_LEN_LO;
                end
                ccr_pkg::PH_LEN_LO: begin
                    n_payload = len_word;
                    if (len_word == '0)
                        fin_unit = 1'b1;
                    else
                        n_phase = ccr_pkg::PH_PAYLOAD;
                end
                ccr_pkg::PH_PAYLOAD: begin
                    n_payload = r_payload - 16'd1;
                    if (r_payload == 16'd1)
                        fin_unit = 1'b1;
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
            if (fin_unit) begin
                n_units = r_units - 16'd1;
                if (n_units != '0)
                    n_phase = ccr_pkg::PH_LEN_HI;
                else if (r_mode == ccr_pkg::MODE_AVC) begin
                    if (r_pps)
                        n_done = 1'b1;
                    else
                        n_phase = ccr_pkg::PH_PPSCNT;
                end else
                    fin_arr = 1'b1;
            end
            if (fin_arr) begin
                n_arrays = r_arrays - 8'd1;
                if (n_arrays == '0)
                    n_done = 1'b1;
                else
                    n_phase = ccr_pkg::PH_ARR_TYPE;
            end
        end
    end

    // results of this byte
    always_comb begin
        o_desc = '0;
        if (active && r_phase == ccr_pkg::PH_LEN_LO) begin
            o_desc.nd  = {1'b0, r_psize} + 3'd1;
            o_desc.len = len_word;
        end else if (active && r_phase == ccr_pkg::PH_PAYLOAD) begin
            o_desc.nd  = 3'd1;
            o_desc.len = {8'd0, i_byte};
        end
        if (i_accept && i_last) begin
            o_desc.st   = 1'b1;
            o_desc.code = !supported ? ccr_pkg::ST_UNSUPP
                        : (n_done ? ccr_pkg::ST_OK : ccr_pkg::ST_TRUNCATED);
            o_desc.warn = (r_mode == ccr_pkg::MODE_AVC) ? n_warn : 1'b0;
        end
        o_push = (o_desc.nd != '0) || o_desc.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_wr_en || (i_accept && i_last)) begin
            r_phase   <= ccr_pkg::PH_HDR;
            r_hdr     <= '0;
            r_psize   <= '0;
            r_units   <= '0;
            r_arrays  <= '0;
            r_payload <= '0;
            r_lenhi   <= '0;
            r_pps     <= 1'b0;
            r_done    <= 1'b0;
            r_warn    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr     <= n_hdr;
            r_psize   <= n_psize;
            r_units   <= n_units;
            r_arrays  <= n_arrays;
            r_payload <= n_payload;
            r_lenhi   <= n_lenhi;
            r_pps     <= n_pps;
            r_done    <= n_done;
            r_warn    <= n_warn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_mode <= ccr_pkg::MODE_NONE;
        else if (i_cfg_wr_en)
            r_mode <= i_cfg_wr_data;
    end

    a_end_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_last && !i_cfg_wr_en) |=> (r_phase == ccr_pkg::PH_HDR && !r_done
                                                  && r_hdr == '0))
        else $error("parse state not cleared after record end");

    a_done_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (o_desc.nd == '0))
        else $error("data emitted after complete parse");

    a_nd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_desc.nd <= 3'd4)
        else $error("too many bytes for one request");

endmodule

// ===== rtl/core/ccr_outq.sv =====
module ccr_outq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  ccr_pkg::t_desc              i_desc,
    output logic                        o_ready,
    output logic                        o_valid,
    input  logic                        i_take,
    output logic [ccr_pkg::ByteW-1:0]   o_byte,
    output logic [ccr_pkg::UserW-1:0]   o_user,
    output logic                        o_last
);

    ccr_pkg::t_desc                r_q [2];
    logic                          r_wp;
    logic                          r_rp;
    logic [1:0]                    r_cnt;
    logic [ccr_pkg::NdW-1:0]       r_pos;

    ccr_pkg::t_desc                head;
    logic [ccr_pkg::NdW-1:0]       total;
    logic [ccr_pkg::NdW-1:0]       k;
    logic                          is_st;
    logic                          pop;
    logic                          wr;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign head    = r_q[r_rp];
    assign total   = head.nd + {2'b00, head.st};
    assign is_st   = (r_pos == head.nd);
    assign k       = head.nd - r_pos - 3'd1;
    assign o_last  = (r_pos == total - 3'd1);
    assign pop     = o_valid && i_take && o_last;
    assign wr      = i_push && o_ready;

    // prefix byte k counts down from the most significant; above 16 bits it is zero
    always_comb begin
        o_byte = '0;
        o_user = '0;
        if (is_st) begin
            o_user = {head.warn, head.code, 1'b1};
        end else begin
            case (k)
                3'd0:    o_byte = head.len[7:0];
                3'd1:    o_byte = head.len[15:8];
                default: o_byte = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr)
            r_q[r_wp] <= i_desc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
            r_pos <= '0;
        end else begin
            if (wr)
                r_wp <= ~r_wp;
            if (pop) begin
                r_rp  <= ~r_rp;
                r_pos <= '0;
            end else if (o_valid && i_take) begin
                r_pos <= r_pos + 3'd1;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, pop};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("request queue overflow");

    a_head_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (total != '0 && r_pos < total))
        else $error("queued entry with no result or position past its end");

    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> (r_pos == '0))
        else $error("position left over on empty queue");

endmodule

// ===== rtl/core/codec_config_record_to_length_prefixed.sv =====
// Channel    Dir  Handshake                    Contents
// s_axis     in   s_axis_tvalid/s_axis_tready  tdata: record_byte; tlast: record_end
// m_axis     out  m_axis_tvalid/m_axis_tready  tdata: out_byte; tuser: status; tlast: run end
// cfg        in   i_cfg_wr_en                  i_cfg_wr_data: codec_mode
//
// A record byte is parsed in the cycle it is accepted; its results go into a
// two-entry request queue, so one byte per cycle is taken while an entry is
// free; each byte yields at most one entry (a payload byte, a prefix or a status).
// A length field yields 1 to 4 prefix bytes and the record end one more
// status result; the output port then drains one result per cycle while
// m_axis_tready is high; s_axis_tready drops only when both queue entries are occupied.
// Reset is synchronous, active low; a codec_mode write also restarts the parse.
module codec_config_record_to_length_prefixed (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [1:0]                  i_cfg_wr_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [ccr_pkg::ByteW-1:0]   s_axis_tdata,   // [7:0] record_byte
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [ccr_pkg::ByteW-1:0]   m_axis_tdata,   // [7:0] out_byte
    output logic [ccr_pkg::UserW-1:0]   m_axis_tuser,   // [0] is_status, [2:1] status_code,
                                                        // [3] reserved_warning
    output logic                        m_axis_tlast
);

    logic            accept;
    logic            push;
    ccr_pkg::t_desc  desc;

    assign accept = s_axis_tvalid && s_axis_tready;

    ccr_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_byte        (s_axis_tdata),
        .i_last        (s_axis_tlast),
        .o_push        (push),
        .o_desc        (desc)
    );

    ccr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (desc),
        .o_ready (s_axis_tready),
        .o_valid (m_axis_tvalid),
        .i_take  (m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_user  (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

endmodule

// ===== sim/tb_codec_config_record_to_length_prefixed.sv =====
`timescale 1ns / 100ps

module tb_codec_config_record_to_length_prefixed;

    localparam logic [1:0] MODE_RSVD = 2'd3;
    localparam int unsigned RUN_LIMIT = 400000;
    localparam int unsigned RANDOM_ITEMS = 330;
    localparam int unsigned IDLE_WAIT = 8;
    localparam int unsigned MAX_PRINTS = 40;

    typedef struct packed {
        logic [7:0] data;
        logic       st;
        logic [1:0] code;
        logic       warn;
        logic       eor;
    } t_out;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_STATUS
    } t_chk;

    typedef struct packed {
        logic       wr;
        logic [1:0] mode;
        logic [7:0] b;
        logic       eor;
        t_chk       chk;
        logic [1:0] code;
        logic       warn;
    } t_row;

    localparam int unsigned DRILL_N = 24;
    localparam t_row DRILL [DRILL_N] = '{
        // unsupported mode: bytes ignored, status only
        '{1'b1, ccr_pkg::MODE_NONE, 8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_NONE, 8'hFF, 1'b1, CHK_STATUS, ccr_pkg::ST_UNSUPP,    1'b0},
        // avcC: 4-byte prefix, two SPS (second one empty), no PPS, trailing bytes
        '{1'b1, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'hFF, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'hE2, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h01, 1'b0, CHK_MODEL,  ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'hAB, 1'b0, CHK_MODEL,  ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_MODEL,  ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h55, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h77, 1'b1, CHK_STATUS, ccr_pkg::ST_OK,        1'b0},
        // restart mid-record, then a short record with bad reserved bits
        '{1'b0, ccr_pkg::MODE_AVC,  8'h12, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b1, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h00, 1'b0, CHK_NONE,   ccr_pkg::ST_OK,        1'b0},
        '{1'b0, ccr_pkg::MODE_AVC,  8'h1F, 1'b1, CHK_STATUS, ccr_pkg::ST_TRUNCATED, 1'b1},
        // reserved mode value acts as unsupported
        '{1'b1, MODE_RSVD,          8'h80, 1'b1, CHK_STATUS, ccr_pkg::ST_UNSUPP,    1'b0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_wr_en = 1'b0;
    logic [1:0] i_cfg_wr_data = 2'd0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;
    logic       s_axis_tlast = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic [3:0] m_axis_tuser;
    logic       m_axis_tlast;

    codec_config_record_to_length_prefixed uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] record_byte
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [7:0] out_byte
        .m_axis_tuser  (m_axis_tuser),    // [0] is_status, [2:1] status_code, [3] warning
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // parse state of the converter
    logic [1:0]      cur_mode;
    ccr_pkg::t_phase ph;
    logic [4:0]      hdr_cnt;
    logic [2:0]      pfx_n;
    logic [15:0]     unit_cnt;
    logic [7:0]      arr_cnt;
    logic [15:0]     pay_cnt;
    logic [7:0]      hi_byte;
    logic            pps_side;
    logic            walk_done;
    logic            rsv_warn;

    t_out       step_out[$];
    t_out       conv_due[$];
    logic [7:0] rec_bytes[$];
    int         mism = 0;
    int         cyc = 0;
    int         burst_left = 0;
    int         fed_items = 0;
    int         stall_style = 0;
    int         stall_span = 0;

    function automatic void restart_walk();
        ph = ccr_pkg::PH_HDR;
        hdr_cnt = '0;
        pfx_n = 3'd1;
        unit_cnt = '0;
        arr_cnt = '0;
        pay_cnt = '0;
        hi_byte = '0;
        pps_side = 1'b0;
        walk_done = 1'b0;
        rsv_warn = 1'b0;
    endfunction

    function automatic void emit(input logic [7:0] d, input logic st,
                                 input logic [1:0] code, input logic warn);
        t_out r;
        r.data = d;
        r.st = st;
        r.code = code;
        r.warn = warn;
        r.eor = 1'b0;
        step_out.push_back(r);
    endfunction

    function automatic void close_array();
        arr_cnt = arr_cnt - 8'd1;
        if (arr_cnt == 8'd0) begin
            walk_done = 1'b1;
        end else begin
            ph = ccr_pkg::PH_ARR_TYPE;
        end
    endfunction

    function automatic void close_unit();
        unit_cnt = unit_cnt - 16'd1;
        if (unit_cnt != 16'd0) begin
            ph = ccr_pkg::PH_LEN_HI;
        end else if (cur_mode == ccr_pkg::MODE_AVC) begin
            if (pps_side) begin
                walk_done = 1'b1;
            end else begin
                ph = ccr_pkg::PH_PPSCNT;
            end
        end else begin
            close_array();
        end
    endfunction

    function automatic void walk_byte(input logic [7:0] b);
        logic [15:0] len;
        int k;
        case (ph)
            ccr_pkg::PH_HDR: begin
                if (cur_mode == ccr_pkg::MODE_AVC) begin
                    if (hdr_cnt == ccr_pkg::AVC_LEN_POS) begin
                        if ((b & ccr_pkg::AVC_LEN_RSV) != ccr_pkg::AVC_LEN_RSV)
                            rsv_warn = 1'b1;
                        pfx_n = {1'b0, b[1:0]} + 3'd1;
                    end else if (hdr_cnt == ccr_pkg::AVC_SPS_POS) begin
                        if ((b & ccr_pkg::AVC_SPS_RSV) != ccr_pkg::AVC_SPS_RSV)
                            rsv_warn = 1'b1;
                        unit_cnt = {8'd0, b & ccr_pkg::AVC_SPS_MSK};
                        pps_side = 1'b0;
                        ph = (unit_cnt == 16'd0) ? ccr_pkg::PH_PPSCNT : ccr_pkg::PH_LEN_HI;
                    end
                end else begin
                    if (hdr_cnt == ccr_pkg::HEVC_LEN_POS) begin
                        pfx_n = {1'b0, b[1:0]} + 3'd1;
                    end else if (hdr_cnt == ccr_pkg::HEVC_ARR_POS) begin
                        arr_cnt = b;
                        if (arr_cnt == 8'd0) begin
                            walk_done = 1'b1;
                        end else begin
                            ph = ccr_pkg::PH_ARR_TYPE;
                        end
                    end
                end
                hdr_cnt = hdr_cnt + 5'd1;
            end
            ccr_pkg::PH_PPSCNT: begin
                unit_cnt = {8'd0, b};
                pps_side = 1'b1;
                if (unit_cnt == 16'd0) begin
                    walk_done = 1'b1;
                end else begin
                    ph = ccr_pkg::PH_LEN_HI;
                end
            end
            ccr_pkg::PH_ARR_TYPE: begin
                ph = ccr_pkg::PH_ARR_CNT_HI;
            end
            ccr_pkg::PH_ARR_CNT_HI: begin
                hi_byte = b;
                ph = ccr_pkg::PH_ARR_CNT_LO;
            end
            ccr_pkg::PH_ARR_CNT_LO: begin
                unit_cnt = {hi_byte, b};
                if (unit_cnt == 16'd0) begin
                    close_array();
                end else begin
                    ph = ccr_pkg::PH_LEN_HI;
                end
            end
            ccr_pkg::PH_LEN_HI: begin
                hi_byte = b;
                ph = ccr_pkg::PH_LEN_LO;
            end
            ccr_pkg::PH_LEN_LO: begin
                len = {hi_byte, b};
                // big-endian prefix, zero-padded above bit 15
                for (k = int'(pfx_n) - 1; k >= 0; k--) begin
                    emit((k == 1) ? len[15:8] : (k == 0) ? len[7:0] : 8'h00,
                         1'b0, ccr_pkg::ST_OK, 1'b0);
                end
                pay_cnt = len;
                if (len == 16'd0) begin
                    close_unit();
                end else begin
                    ph = ccr_pkg::PH_PAYLOAD;
                end
            end
            default: begin
                emit(b, 1'b0, ccr_pkg::ST_OK, 1'b0);
                pay_cnt = pay_cnt - 16'd1;
                if (pay_cnt == 16'd0) close_unit();
            end
        endcase
    endfunction

    // results of one record byte land in step_out; returns whether the byte mattered
    function automatic logic convert_byte(input logic [7:0] b, input logic eor);
        logic supported;
        logic busy;
        logic [1:0] code;
        step_out.delete();
        supported = (cur_mode == ccr_pkg::MODE_AVC) || (cur_mode == ccr_pkg::MODE_HEVC);
        busy = supported && !walk_done;
        if (busy) walk_byte(b);
        if (eor) begin
            code = !supported ? ccr_pkg::ST_UNSUPP
                 : (walk_done ? ccr_pkg::ST_OK : ccr_pkg::ST_TRUNCATED);
            emit(8'h00, 1'b1, code, (cur_mode == ccr_pkg::MODE_AVC) ? rsv_warn : 1'b0);
            restart_walk();
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].eor = 1'b1;
        return busy || eor;
    endfunction

    task automatic flag(input string what, input int got, input int want);
        mism++;
        if (mism <= MAX_PRINTS) begin
            $display("mismatch in %s: got %0d, want %0d (cycle %0d)", what, got, want, cyc);
        end
    endtask

    task automatic set_mode(input logic [1:0] m);
        s_axis_tvalid <= 1'b0;
        while (conv_due.size() != 0) @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_mode = m;
        restart_walk();
        burst_left = 0;
    endtask

    task automatic send_record_byte(input logic [7:0] b, input logic eor, input t_chk chk,
                                    input logic [1:0] code, input logic warn);
        int gap;
        t_out st_res;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= eor;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        burst_left--;
        void'(convert_byte(b, eor));
        fed_items++;
        case (chk)
            CHK_MODEL: begin
                foreach (step_out[i]) conv_due.push_back(step_out[i]);
            end
            CHK_STATUS: begin
                st_res = '{8'h00, 1'b1, code, warn, 1'b1};
                conv_due.push_back(st_res);
            end
            default: ;
        endcase
    endtask

    task automatic add_unit();
        int len;
        if ($urandom_range(0, 31) == 0) begin
            len = $urandom_range(256, 300);
        end else if ($urandom_range(0, 15) == 0) begin
            len = $urandom_range(7, 40);
        end else begin
            len = $urandom_range(0, 6);
        end
        rec_bytes.push_back(len[15:8]);
        rec_bytes.push_back(len[7:0]);
        repeat (len) rec_bytes.push_back(8'($urandom));
    endtask

    task automatic build_record(input logic [1:0] m);
        int n;
        int arrays;
        rec_bytes.delete();
        if (m == ccr_pkg::MODE_AVC) begin
            repeat (4) rec_bytes.push_back(8'($urandom));
            rec_bytes.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom)
                                : (ccr_pkg::AVC_LEN_RSV | 8'($urandom_range(0, 3))));
            n = $urandom_range(0, 2);
            rec_bytes.push_back(($urandom_range(0, 7) == 0)
                                ? {3'($urandom), 5'(n)} : {3'b111, 5'(n)});
            repeat (n) add_unit();
            n = $urandom_range(0, 2);
            rec_bytes.push_back(8'(n));
            repeat (n) add_unit();
        end else begin
            repeat (22) rec_bytes.push_back(8'($urandom));
            arrays = $urandom_range(0, 3);
            rec_bytes.push_back(8'(arrays));
            repeat (arrays) begin
                rec_bytes.push_back(8'($urandom));
                rec_bytes.push_back(8'h00);
                n = $urandom_range(0, 2);
                rec_bytes.push_back(8'(n));
                repeat (n) add_unit();
            end
        end
        repeat ($urandom_range(0, 2)) rec_bytes.push_back(8'($urandom));
        // cut some records short
        if (rec_bytes.size() > 1 && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, rec_bytes.size() - 1);
            while (rec_bytes.size() > n) void'(rec_bytes.pop_back());
        end
    endtask

    // receiver stalls on a style that is redrawn when its span runs out
    always @(posedge i_clk) begin
        if (stall_span == 0) begin
            stall_style <= $urandom_range(0, 3);
            stall_span <= $urandom_range(20, 80);
        end else begin
            stall_span <= stall_span - 1;
        end
        case (stall_style)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (cyc % 4) != 3;
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (conv_due.size() == 0) begin
                flag("unrequested result, out_byte", m_axis_tdata, 0);
            end else begin
                want = conv_due.pop_front();
                if (m_axis_tdata !== want.data) flag("out_byte", m_axis_tdata, want.data);
                if (m_axis_tuser[0] !== want.st) flag("is_status", m_axis_tuser[0], want.st);
                if (m_axis_tuser[2:1] !== want.code)
                    flag("status_code", m_axis_tuser[2:1], want.code);
                if (m_axis_tuser[3] !== want.warn)
                    flag("reserved_warning", m_axis_tuser[3], want.warn);
                if (m_axis_tlast !== want.eor) flag("last_of_run", m_axis_tlast, want.eor);
            end
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int pick;
        int n;
        logic [1:0] m;
        cur_mode = ccr_pkg::MODE_NONE;
        restart_walk();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DRILL_N; i++) begin
            if (DRILL[i].wr) set_mode(DRILL[i].mode);
            send_record_byte(DRILL[i].b, DRILL[i].eor, DRILL[i].chk,
                             DRILL[i].code, DRILL[i].warn);
        end

        while (fed_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                // noise: random bytes with stray record ends
                set_mode(2'($urandom_range(0, 2)));
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    send_record_byte(8'($urandom), (i == n - 1) || ($urandom_range(0, 7) == 0),
                                     CHK_MODEL, ccr_pkg::ST_OK, 1'b0);
                end
            end else begin
                m = (pick == 9) ? ccr_pkg::MODE_NONE
                  : (pick <= 4) ? ccr_pkg::MODE_AVC : ccr_pkg::MODE_HEVC;
                if (m != cur_mode || $urandom_range(0, 1) == 0) set_mode(m);
                if (m == ccr_pkg::MODE_NONE) begin
                    rec_bytes.delete();
                    repeat ($urandom_range(1, 4)) rec_bytes.push_back(8'($urandom));
                end else begin
                    build_record(m);
                end
                foreach (rec_bytes[i]) begin
                    send_record_byte(rec_bytes[i], i == rec_bytes.size() - 1,
                                     CHK_MODEL, ccr_pkg::ST_OK, 1'b0);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        while (conv_due.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mism == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ccr_pkg.sv
rtl/core/ccr_parse.sv
rtl/core/ccr_outq.sv
rtl/core/codec_config_record_to_length_prefixed.sv
sim/tb_codec_config_record_to_length_prefixed.sv
